/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// clocked, reset-qualified concurrent assertion wrappers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on clk_i, off while rst_ni is low
`define SRMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form of the above
`define SRMS_ASSERT_IMP(lbl, ante, cons, msg) \
  `SRMS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* hw/rtl/srms_pkg.sv */
// ---------------------------------------------------------------------------
// srms_pkg
// types and constants of the stepper ramp move sequencer
// ---------------------------------------------------------------------------
package srms_pkg;

  localparam int unsigned RAMP_ENTRIES_DEF = 5;
  localparam int unsigned PERIOD_BITS_DEF  = 24;

  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned TMR_W       = 24;
  localparam int unsigned STEP_W      = 14;
  localparam int unsigned PHASE_W     = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_PERIOD_0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_INTERVAL   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_DWELL_TICKS     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_MOVE_STEPS = 3'd7;

  // register reset values and the half-move step limit
  localparam logic [CFG_DATA_W-1:0] RST_RAMP_PERIOD_0 = 24'd62500;
  localparam logic [CFG_DATA_W-1:0] RST_RAMP_PERIOD_1 = 24'd18500;
  localparam logic [CFG_DATA_W-1:0] RST_RAMP_PERIOD_N = 24'd9375;
  localparam logic [TMR_W-1:0]      RST_RAMP_INTERVAL = 24'd10000;
  localparam logic [TMR_W-1:0]      RST_DWELL_TICKS   = 24'd25000;
  localparam logic [STEP_W-1:0]     RST_HALF_STEPS    = 14'd3200;
  localparam logic [STEP_W:0]       HALF_STEPS_MAX    = 15'd8192;

  // command codes
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_HOME  = 2'd2;

  // phase codes as seen on the output word
  localparam logic [PHASE_W-1:0] PH_CODE_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CODE_FWD   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CODE_DWELL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CODE_RET   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CODE_HOME  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FWD   = 5'b00010,
    ST_DWELL = 5'b00100,
    ST_RET   = 5'b01000,
    ST_HOME  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [4:0] pad;
    logic       home_sensor;
    logic [1:0] command;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic [PHASE_W-1:0] phase;
    logic               busy_res;
    logic               direction;
    logic               step_out;
  } out_word_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_e st);
    logic [PHASE_W-1:0] code;
    unique case (st)
      ST_IDLE:  code = PH_CODE_IDLE;
      ST_FWD:   code = PH_CODE_FWD;
      ST_DWELL: code = PH_CODE_DWELL;
      ST_RET:   code = PH_CODE_RET;
      ST_HOME:  code = PH_CODE_HOME;
      default:  code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/stepper_ramp_move_sequencer.sv */
// ---------------------------------------------------------------------------
// stepper_ramp_move_sequencer
// one timer tick per input word; ramped step pulse train with forward,
// dwell, return and homing phases
// throughput: one word per cycle while the output is not stalled;
// words pass the input register, then the state/result register
// reset clears all sequencing state, restores register defaults, no words held
// ---------------------------------------------------------------------------
module stepper_ramp_move_sequencer #(
  parameter int unsigned RAMP_ENTRIES = srms_pkg::RAMP_ENTRIES_DEF,
  parameter int unsigned PERIOD_BITS  = srms_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // command[1:0], home_sensor
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // step_out, direction,
                                                           // busy_res, phase[2:0]
  input  logic                            cfg_we_i,
  input  logic [srms_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [srms_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(RAMP_ENTRIES);
  localparam int unsigned TMR_W  = srms_pkg::TMR_W;
  localparam int unsigned STEP_W = srms_pkg::STEP_W;

  // configuration registers
  logic [PERIOD_BITS-1:0] ramp_per_q [RAMP_ENTRIES];
  logic [TMR_W-1:0]       ramp_iv_q;
  logic [TMR_W-1:0]       dwell_q;
  logic [STEP_W-1:0]      half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RAMP_ENTRIES; i++) begin
        if (i == 0) begin
          ramp_per_q[i] <= PERIOD_BITS'(srms_pkg::RST_RAMP_PERIOD_0);
        end else if (i == 1) begin
          ramp_per_q[i] <= PERIOD_BITS'(srms_pkg::RST_RAMP_PERIOD_1);
        end else begin
          ramp_per_q[i] <= PERIOD_BITS'(srms_pkg::RST_RAMP_PERIOD_N);
        end
      end
      ramp_iv_q <= srms_pkg::RST_RAMP_INTERVAL;
      dwell_q   <= srms_pkg::RST_DWELL_TICKS;
      half_q    <= srms_pkg::RST_HALF_STEPS;
    end else if (cfg_we_i) begin
      for (int i = 0; i < RAMP_ENTRIES; i++) begin
        if (cfg_addr_i == srms_pkg::CFG_RAMP_PERIOD_0 + srms_pkg::CFG_ADDR_W'(i)) begin
          ramp_per_q[i] <= PERIOD_BITS'(cfg_wdata_i);
        end
      end
      if (cfg_addr_i == srms_pkg::CFG_RAMP_INTERVAL) begin
        ramp_iv_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == srms_pkg::CFG_DWELL_TICKS) begin
        dwell_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == srms_pkg::CFG_HALF_MOVE_STEPS) begin
        half_q <= cfg_wdata_i[STEP_W-1:0];
      end
    end
  end

  // input register
  logic              in_valid_q;
  srms_pkg::in_word_t in_q;
  logic              out_valid_q;
  srms_pkg::out_word_t out_q;
  logic              out_free;
  logic              advance;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= srms_pkg::in_word_t'(s_axis_tdata_i);
    end
  end

  // sequencing state
  srms_pkg::phase_e       phase_q, phase_d;
  logic [PERIOD_BITS-1:0] per_cnt_q, per_cnt_d;
  logic [PERIOD_BITS-1:0] cur_per_q, cur_per_d;
  logic [IDX_W-1:0]       ramp_idx_q, ramp_idx_d;
  logic [TMR_W-1:0]       ramp_tmr_q, ramp_tmr_d;
  logic [STEP_W-1:0]      step_cnt_q, step_cnt_d;
  logic [TMR_W-1:0]       dwell_tmr_q, dwell_tmr_d;
  logic                   dir_q, dir_d;
  logic                   busy_q, busy_d;
  logic                   sens_q, sens_d;

  logic                   fell;
  logic [TMR_W-1:0]       iv_eff;
  logic [TMR_W-1:0]       dwell_eff;
  logic [STEP_W:0]        half_eff;
  logic [STEP_W:0]        limit;
  logic                   ramp_wrap;
  logic [IDX_W-1:0]       ramp_idx_nxt;
  logic [PERIOD_BITS-1:0] ent_raw;
  logic [PERIOD_BITS-1:0] ent_run;
  logic [PERIOD_BITS-1:0] ent_first;
  logic                   per_done;
  logic                   step_done;
  logic                   dwell_done;
  logic                   run_d;

  always_comb begin
    fell      = sens_q && !in_q.home_sensor;
    iv_eff    = (ramp_iv_q == '0) ? TMR_W'(1) : ramp_iv_q;
    dwell_eff = (dwell_q == '0) ? TMR_W'(1) : dwell_q;
    if (half_q == '0) begin
      half_eff = (STEP_W+1)'(1);
    end else if ({1'b0, half_q} > srms_pkg::HALF_STEPS_MAX) begin
      half_eff = srms_pkg::HALF_STEPS_MAX;
    end else begin
      half_eff = {1'b0, half_q};
    end
    limit = (phase_q == srms_pkg::ST_HOME) ? {half_eff[STEP_W-1:0], 1'b0} : half_eff;

    ramp_wrap = ({1'b0, ramp_tmr_q} + (TMR_W+1)'(1)) >= {1'b0, iv_eff};
    if (ramp_wrap && ramp_idx_q != IDX_W'(RAMP_ENTRIES - 1)) begin
      ramp_idx_nxt = ramp_idx_q + IDX_W'(1);
    end else begin
      ramp_idx_nxt = ramp_idx_q;
    end
    ent_raw   = ramp_per_q[ramp_idx_nxt];
    ent_run   = (ent_raw < PERIOD_BITS'(2)) ? PERIOD_BITS'(2) : ent_raw;
    ent_first = (ramp_per_q[0] < PERIOD_BITS'(2)) ? PERIOD_BITS'(2) : ramp_per_q[0];

    per_done   = ({1'b0, per_cnt_q} + (PERIOD_BITS+1)'(1)) >= {1'b0, cur_per_q};
    step_done  = ({1'b0, step_cnt_q} + (STEP_W+1)'(1)) >= limit;
    dwell_done = ({1'b0, dwell_tmr_q} + (TMR_W+1)'(1)) >= {1'b0, dwell_eff};

    phase_d     = phase_q;
    per_cnt_d   = per_cnt_q;
    cur_per_d   = cur_per_q;
    ramp_idx_d  = ramp_idx_q;
    ramp_tmr_d  = ramp_tmr_q;
    step_cnt_d  = step_cnt_q;
    dwell_tmr_d = dwell_tmr_q;
    dir_d       = dir_q;
    busy_d      = busy_q;
    sens_d      = sens_q;

    if (advance) begin
      sens_d = in_q.home_sensor;
      unique case (phase_q)
        srms_pkg::ST_IDLE: begin
          if (in_q.command == srms_pkg::CMD_START) begin
            busy_d     = 1'b1;
            dir_d      = 1'b0;
            phase_d    = srms_pkg::ST_FWD;
            step_cnt_d = '0;
            per_cnt_d  = '0;
            ramp_idx_d = '0;
            ramp_tmr_d = '0;
            cur_per_d  = ent_first;
          end else if (in_q.command == srms_pkg::CMD_HOME) begin
            dir_d = 1'b1;
            if (in_q.home_sensor) begin
              busy_d     = 1'b1;
              phase_d    = srms_pkg::ST_HOME;
              step_cnt_d = '0;
              per_cnt_d  = '0;
              ramp_idx_d = '0;
              ramp_tmr_d = '0;
              cur_per_d  = ent_first;
            end
          end
        end
        srms_pkg::ST_DWELL: begin
          if (dwell_done) begin
            dwell_tmr_d = '0;
            if (in_q.home_sensor) begin
              phase_d    = srms_pkg::ST_RET;
              step_cnt_d = '0;
              per_cnt_d  = '0;
              ramp_idx_d = '0;
              ramp_tmr_d = '0;
              cur_per_d  = ent_first;
            end else begin
              phase_d = srms_pkg::ST_IDLE;
              busy_d  = 1'b0;
            end
          end else begin
            dwell_tmr_d = dwell_tmr_q + TMR_W'(1);
          end
        end
        srms_pkg::ST_FWD, srms_pkg::ST_RET, srms_pkg::ST_HOME: begin
          if (phase_q != srms_pkg::ST_FWD && fell) begin
            phase_d = srms_pkg::ST_IDLE;
            busy_d  = 1'b0;
          end else begin
            ramp_idx_d = ramp_idx_nxt;
            ramp_tmr_d = ramp_wrap ? '0 : ramp_tmr_q + TMR_W'(1);
            if (per_done) begin
              per_cnt_d = '0;
              cur_per_d = ent_run;
              if (step_done) begin
                if (phase_q == srms_pkg::ST_FWD) begin
                  phase_d     = srms_pkg::ST_DWELL;
                  dwell_tmr_d = '0;
                  dir_d       = 1'b1;
                end else begin
                  phase_d = srms_pkg::ST_IDLE;
                  busy_d  = 1'b0;
                end
              end else begin
                step_cnt_d = step_cnt_q + STEP_W'(1);
              end
            end else begin
              per_cnt_d = per_cnt_q + PERIOD_BITS'(1);
            end
          end
        end
        default: begin
          phase_d = srms_pkg::ST_IDLE;
          busy_d  = 1'b0;
        end
      endcase
    end

    run_d = (phase_d == srms_pkg::ST_FWD) || (phase_d == srms_pkg::ST_RET) ||
            (phase_d == srms_pkg::ST_HOME);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= srms_pkg::ST_IDLE;
      per_cnt_q   <= '0;
      cur_per_q   <= '0;
      ramp_idx_q  <= '0;
      ramp_tmr_q  <= '0;
      step_cnt_q  <= '0;
      dwell_tmr_q <= '0;
      dir_q       <= 1'b0;
      busy_q      <= 1'b0;
      sens_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      per_cnt_q   <= per_cnt_d;
      cur_per_q   <= cur_per_d;
      ramp_idx_q  <= ramp_idx_d;
      ramp_tmr_q  <= ramp_tmr_d;
      step_cnt_q  <= step_cnt_d;
      dwell_tmr_q <= dwell_tmr_d;
      dir_q       <= dir_d;
      busy_q      <= busy_d;
      sens_q      <= sens_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.pad       <= '0;
      out_q.step_out  <= run_d && (per_cnt_d < (cur_per_d >> 1));
      out_q.direction <= dir_d;
      out_q.busy_res  <= busy_d;
      out_q.phase     <= srms_pkg::phase_code(phase_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

/* hw/rtl/srms_checker.sv */
// ---------------------------------------------------------------------------
// srms_checker
// port-level checks of the stepper ramp move sequencer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  srms_pkg::out_word_t w;
  logic                run_ph;
  logic                rev_ph;
  logic                stall;
  logic                step_seen;
  logic                busy_ok;
  logic                moving;
  logic                dir_ok;

  assign w      = srms_pkg::out_word_t'(m_axis_tdata_o);
  assign run_ph = (w.phase == srms_pkg::PH_CODE_FWD) || (w.phase == srms_pkg::PH_CODE_RET) ||
                  (w.phase == srms_pkg::PH_CODE_HOME);
  assign rev_ph = (w.phase == srms_pkg::PH_CODE_DWELL) ||
                  (w.phase == srms_pkg::PH_CODE_RET) || (w.phase == srms_pkg::PH_CODE_HOME);

  assign stall     = m_axis_tvalid_o && !m_axis_tready_i;
  assign step_seen = m_axis_tvalid_o && w.step_out;
  assign busy_ok   = w.busy_res == (w.phase != srms_pkg::PH_CODE_IDLE);
  assign moving    = m_axis_tvalid_o && (w.phase != srms_pkg::PH_CODE_IDLE);
  assign dir_ok    = w.direction == rev_ph;

  // stalled output word holds
  `SRMS_ASSERT(a_out_hold, stall |=> m_axis_tvalid_o && $stable(w), "srms: held word changed")

  // pulses only while moving
  `SRMS_ASSERT_IMP(a_step_phase, step_seen, run_ph, "srms: step pulse outside a move")

  // busy exactly when not idle
  `SRMS_ASSERT_IMP(a_busy_phase, m_axis_tvalid_o, busy_ok, "srms: busy and phase disagree")

  // direction follows phase
  `SRMS_ASSERT_IMP(a_dir_phase, moving, dir_ok, "srms: direction wrong for phase")

endmodule

bind stepper_ramp_move_sequencer srms_checker u_srms_checker (.*);
